FILE: hw/rtl/opwm_pkg.sv
// Shared types, constants and modular helpers of the order-preserving window matcher.
// Used by the multiplier, remainder and top-level files; depends on nothing.
package opwm_pkg;

  localparam int          VAL_W    = 30;
  localparam logic [29:0] MOD_M    = 30'd1000000009;
  localparam logic [29:0] P_BASE   = 30'd1000003;
  localparam logic [29:0] P_INV    = 30'd27749917;
  localparam logic [31:0] BARRETT_MU = 32'd1152921494;  // floor(2^60 / M)

  localparam int PLEN_W   = 11;
  localparam int TEXT_W   = 12;
  localparam int COUNT_W  = 32;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;
  localparam int DIV_STEPS = 30;

  localparam logic REG_PATTERN_LENGTH = 1'b0;

  typedef struct packed {
    logic [VAL_W-1:0] sum;
    logic [VAL_W-1:0] scale;
  } node_t;

  typedef struct packed {
    logic             go;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } mm_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] res;
  } mm_rsp_t;

  typedef struct packed {
    logic              go;
    logic [VAL_W-1:0]  dividend;
    logic [PLEN_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic              done;
    logic [PLEN_W-1:0] rem;
  } rem_rsp_t;

  // both operands already below M
  function automatic logic [VAL_W-1:0] addmod(input logic [VAL_W-1:0] a,
                                              input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MOD_M}) s = s - {1'b0, MOD_M};
    return s[VAL_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/opwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stands alone; instantiated for the tree store and the window ring.
module opwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/opwm_mulmod.sv
// Shared modular multiplier: a*b mod M by Barrett reduction, one 32x32 multiplier reused
// for the product, the quotient estimate and the quotient times M. Uses opwm_pkg.
module opwm_mulmod import opwm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  mm_req_t req,
  output mm_rsp_t rsp
);

  typedef enum logic [2:0] {MM_IDLE, MM_AB, MM_MU, MM_QM, MM_SUB, MM_FIX1, MM_FIX2} mm_state_t;

  localparam logic [31:0] M32 = 32'(MOD_M);

  mm_state_t        st_r;
  logic [VAL_W-1:0] a_r, b_r;
  logic [59:0]      x_r;
  logic [63:0]      p_r;
  logic [31:0]      r_r;
  logic             done_r;
  logic [VAL_W-1:0] res_r;
  logic [31:0]      mul_x, mul_y;
  logic [63:0]      prod;

  always_comb begin
    unique case (st_r)
      MM_AB: begin
        mul_x = {2'b0, a_r};
        mul_y = {2'b0, b_r};
      end
      MM_MU: begin
        mul_x = {1'b0, x_r[59:29]};
        mul_y = BARRETT_MU;
      end
      MM_QM: begin
        mul_x = {1'b0, p_r[61:31]};
        mul_y = M32;
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign prod = mul_x * mul_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= MM_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        MM_IDLE: begin
          if (req.go) begin
            a_r  <= req.a;
            b_r  <= req.b;
            st_r <= MM_AB;
          end
        end
        MM_AB: begin
          x_r  <= prod[59:0];
          st_r <= MM_MU;
        end
        MM_MU: begin
          p_r  <= prod;
          st_r <= MM_QM;
        end
        MM_QM: begin
          p_r  <= prod;
          st_r <= MM_SUB;
        end
        MM_SUB: begin
          // remainder estimate is below 3M, so 32 bits hold it
          r_r  <= x_r[31:0] - p_r[31:0];
          st_r <= MM_FIX1;
        end
        MM_FIX1: begin
          if (r_r >= M32) r_r <= r_r - M32;
          st_r <= MM_FIX2;
        end
        MM_FIX2: begin
          res_r  <= (r_r >= M32) ? VAL_W'(r_r - M32) : VAL_W'(r_r);
          done_r <= 1'b1;
          st_r   <= MM_IDLE;
        end
        default: st_r <= MM_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

FILE: hw/rtl/opwm_rem.sv
// Restoring remainder unit: text index modulo window length, one bit per cycle.
// Uses opwm_pkg for the request and response types.
module opwm_rem import opwm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  rem_req_t req,
  output rem_rsp_t rsp
);

  typedef enum logic {RM_IDLE, RM_RUN} rm_state_t;

  rm_state_t         st_r;
  logic [VAL_W-1:0]  dvd_r;
  logic [PLEN_W-1:0] dsr_r;
  logic [PLEN_W-1:0] rem_r;
  logic [4:0]        cnt_r;
  logic              done_r;
  logic [PLEN_W:0]   trial;

  assign trial = {rem_r, dvd_r[VAL_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= RM_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        RM_IDLE: begin
          if (req.go) begin
            dvd_r <= req.dividend;
            dsr_r <= req.divisor;
            rem_r <= '0;
            cnt_r <= 5'(DIV_STEPS - 1);
            st_r  <= RM_RUN;
          end
        end
        RM_RUN: begin
          if (trial >= {1'b0, dsr_r}) rem_r <= PLEN_W'(trial - {1'b0, dsr_r});
          else rem_r <= trial[PLEN_W-1:0];
          dvd_r <= {dvd_r[VAL_W-2:0], 1'b0};
          if (cnt_r == '0) begin
            done_r <= 1'b1;
            st_r   <= RM_IDLE;
          end else begin
            cnt_r <= cnt_r - 5'd1;
          end
        end
        default: st_r <= RM_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

FILE: hw/rtl/order_preserving_window_matcher_unit.sv
// Order-preserving window matcher: pattern words build a rank hash, text words slide through
// a window kept as a lazily scaled segment tree over the value range, and every result word
// reports window fill, match, match count and the tree root. One word is in flight at a time.
// After reset the tree store's 2*2^ceil(log2 VALUE_RANGE) entries (8192 at the default) are
// cleared while in_stall is high. A pattern word takes two modular multiplies. A text word
// takes the slot remainder and then tree passes, each with modular multiplies and a recompute
// of the nodes on the path to the root; a sliding window takes twice the passes of a filling
// one, and all passes share the single multiplier and the single tree RAM.
module order_preserving_window_matcher_unit import opwm_pkg::*; #(
  parameter int VALUE_RANGE = 4096,
  parameter int WINDOW_MAX  = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [PLEN_W-1:0]  in_pattern_value,
  input  logic [TEXT_W-1:0]  in_text_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_window_full,
  output logic               out_match,
  output logic [COUNT_W-1:0] out_match_count,
  output logic [VAL_W-1:0]   out_window_hash,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [CFG_AW-1:0]  cfg_paddr,
  input  logic [CFG_DW-1:0]  cfg_pwdata,
  output logic [CFG_DW-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  localparam int VAL_AW     = $clog2(VALUE_RANGE);
  localparam int NODE_W     = VAL_AW + 1;
  localparam int TREE_DEPTH = 2 << VAL_AW;
  localparam int CW         = (NODE_W > TEXT_W + 1) ? NODE_W : TEXT_W + 1;
  localparam int RING_AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam logic [CW-1:0]     VR_C      = CW'(VALUE_RANGE);
  localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_PAT_W1, S_PAT_W2, S_REM, S_RING, S_RING2,
    S_SF_START, S_SF_NODE, S_SC_WAIT, S_SC_RD, S_SC_W1, S_SC_W2,
    S_SL_START, S_SL_NODE, S_SL_W, S_SL_RD, S_SL_MW,
    S_PL_A, S_PL_AW, S_PL_B, S_PL_BW, S_PL_C, S_PL_CW, S_PL_M, S_PL_MW,
    S_FIN, S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic [PLEN_W-1:0] pl_r;
  logic              cfg_wr;
  logic              cfg_idx;
  logic [PLEN_W-1:0] n_eff;

  // block state
  logic [PLEN_W-1:0]  fill_r;
  logic [VAL_W-1:0]   tidx_r, target_r, psum_r, cpow_r, root_r;
  logic [COUNT_W-1:0] matches_r;

  // current word
  logic              is_text_r, was_full_r;
  logic [PLEN_W-1:0] pv_r, n_r, slot_r;
  logic [TEXT_W-1:0] tv_r;

  // tree walk
  logic              op_del_r, sl_step_r, sf_stop_r;
  logic [CW-1:0]     from_r, pos_r, lo_r, hi_r, mid;
  logic [VAL_W-1:0]  z_r, val_r, sum_a_r, s_r, scl_r;
  node_t             ent_r;
  logic [NODE_W-1:0] nd_r, pn_r, clr_r;
  logic [NODE_W-1:0] nd_left, nd_right, pn_left, pn_right;

  // memory ports
  logic [NODE_W-1:0] addr_r, waddr_r;
  logic              we_r, ring_we_r;
  node_t             wdata_r, tree_rdata;
  logic [TEXT_W-1:0] ring_rdata;

  // shared units
  logic              mm_go_r, rem_go_r;
  logic [VAL_W-1:0]  mm_a_r, mm_b_r;
  mm_req_t           mm_req;
  mm_rsp_t           mm_rsp;
  rem_req_t          rem_req;
  rem_rsp_t          rem_rsp;

  // output word
  logic               out_valid_r, out_full_r, out_match_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [VAL_W-1:0]   out_hash_r;
  logic               full_now, hit_now;

  assign mid      = lo_r + ((hi_r - lo_r) >> 1);
  assign nd_left  = {nd_r[NODE_W-2:0], 1'b0};
  assign nd_right = {nd_r[NODE_W-2:0], 1'b1};
  assign pn_left  = {pn_r[NODE_W-2:0], 1'b0};
  assign pn_right = {pn_r[NODE_W-2:0], 1'b1};

  assign full_now = (fill_r >= n_r);
  assign hit_now  = is_text_r && full_now && (root_r == target_r);

  always_comb begin
    if (pl_r == '0) n_eff = PLEN_W'(1);
    else if (32'(pl_r) > 32'(WINDOW_MAX)) n_eff = PLEN_W'(WINDOW_MAX);
    else n_eff = pl_r;
  end

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_idx)
      REG_PATTERN_LENGTH: cfg_prdata = {(CFG_DW - PLEN_W)'(0), pl_r};
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pl_r <= PLEN_W'(1);
    end else if (cfg_wr && cfg_idx == REG_PATTERN_LENGTH) begin
      pl_r <= cfg_pwdata[PLEN_W-1:0];
    end
  end

  // ---------------- shared units and memories ----------------
  assign mm_req.go  = mm_go_r;
  assign mm_req.a   = mm_a_r;
  assign mm_req.b   = mm_b_r;

  assign rem_req.go       = rem_go_r;
  assign rem_req.dividend = tidx_r;
  assign rem_req.divisor  = n_r;

  opwm_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  opwm_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  opwm_ram #(.WIDTH($bits(node_t)), .DEPTH(TREE_DEPTH)) u_tree_ram (
    .clk   (clk),
    .we    (we_r),
    .waddr (waddr_r),
    .wdata (wdata_r),
    .raddr (addr_r),
    .rdata (tree_rdata)
  );

  opwm_ram #(.WIDTH(TEXT_W), .DEPTH(WINDOW_MAX)) u_ring_ram (
    .clk   (clk),
    .we    (ring_we_r),
    .waddr (RING_AW'(slot_r)),
    .wdata (tv_r),
    .raddr (RING_AW'(slot_r)),
    .rdata (ring_rdata)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      fill_r      <= '0;
      tidx_r      <= '0;
      target_r    <= '0;
      psum_r      <= '0;
      cpow_r      <= VAL_W'(1);
      matches_r   <= '0;
      root_r      <= '0;
      out_valid_r <= 1'b0;
      mm_go_r     <= 1'b0;
      rem_go_r    <= 1'b0;
      we_r        <= 1'b0;
      ring_we_r   <= 1'b0;
    end else begin
      mm_go_r   <= 1'b0;
      rem_go_r  <= 1'b0;
      we_r      <= 1'b0;
      ring_we_r <= 1'b0;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      unique case (state_r)
        S_CLEAR: begin
          we_r          <= 1'b1;
          waddr_r       <= clr_r;
          wdata_r.sum   <= '0;
          wdata_r.scale <= VAL_W'(1);
          clr_r         <= clr_r + NODE_W'(1);
          if (clr_r == NODE_W'(TREE_DEPTH - 1)) state_r <= S_IDLE;
        end

        S_IDLE: begin
          if (in_valid) begin
            is_text_r <= in_req_type;
            pv_r      <= in_pattern_value;
            tv_r      <= in_text_value;
            n_r       <= n_eff;
            if (!in_req_type) begin
              mm_go_r <= 1'b1;
              mm_a_r  <= cpow_r;
              mm_b_r  <= VAL_W'(in_pattern_value);
              state_r <= S_PAT_W1;
            end else begin
              rem_go_r <= 1'b1;
              state_r  <= S_REM;
            end
          end
        end

        S_PAT_W1: begin
          if (mm_rsp.done) begin
            target_r <= addmod(target_r, mm_rsp.res);
            psum_r   <= addmod(psum_r, cpow_r);
            mm_go_r  <= 1'b1;
            mm_a_r   <= cpow_r;
            mm_b_r   <= P_BASE;
            state_r  <= S_PAT_W2;
          end
        end

        S_PAT_W2: begin
          if (mm_rsp.done) begin
            cpow_r  <= mm_rsp.res;
            state_r <= S_OUT;
          end
        end

        S_REM: begin
          if (rem_rsp.done) begin
            slot_r <= rem_rsp.rem;
            if (fill_r >= n_r) begin
              was_full_r <= 1'b1;
              state_r    <= S_RING;
            end else begin
              // filling: insert only
              was_full_r <= 1'b0;
              op_del_r   <= 1'b0;
              sl_step_r  <= 1'b0;
              from_r     <= CW'(tv_r) + CW'(1);
              pos_r      <= CW'(tv_r);
              z_r        <= P_BASE;
              val_r      <= tidx_r + VAL_W'(1);
              state_r    <= S_SF_START;
            end
          end
        end

        S_RING: state_r <= S_RING2;

        S_RING2: begin
          // drop the oldest value first
          op_del_r  <= 1'b1;
          sl_step_r <= 1'b0;
          from_r    <= CW'(ring_rdata) + CW'(1);
          pos_r     <= CW'(ring_rdata);
          z_r       <= P_INV;
          val_r     <= '0;
          state_r   <= S_SF_START;
        end

        // scale every position at or above from_r
        S_SF_START: begin
          if (from_r >= VR_C) begin
            state_r <= S_SL_START;
          end else begin
            nd_r    <= ROOT_NODE;
            lo_r    <= '0;
            hi_r    <= VR_C;
            state_r <= S_SF_NODE;
          end
        end

        S_SF_NODE: begin
          if (from_r <= mid) begin
            addr_r  <= nd_right;
            state_r <= S_SC_WAIT;
            if (from_r < mid) begin
              sf_stop_r <= 1'b0;
              nd_r      <= nd_left;
              hi_r      <= mid;
            end else begin
              sf_stop_r <= 1'b1;
              pn_r      <= nd_r;
            end
          end else begin
            nd_r <= nd_right;
            lo_r <= mid;
          end
        end

        S_SC_WAIT: state_r <= S_SC_RD;

        S_SC_RD: begin
          ent_r   <= tree_rdata;
          mm_go_r <= 1'b1;
          mm_a_r  <= tree_rdata.scale;
          mm_b_r  <= z_r;
          state_r <= S_SC_W1;
        end

        S_SC_W1: begin
          if (mm_rsp.done) begin
            scl_r   <= mm_rsp.res;
            mm_go_r <= 1'b1;
            mm_a_r  <= ent_r.sum;
            mm_b_r  <= z_r;
            state_r <= S_SC_W2;
          end
        end

        S_SC_W2: begin
          if (mm_rsp.done) begin
            we_r          <= 1'b1;
            waddr_r       <= addr_r;
            wdata_r.sum   <= mm_rsp.res;
            wdata_r.scale <= scl_r;
            state_r       <= sf_stop_r ? S_PL_A : S_SF_NODE;
          end
        end

        // walk to the leaf of pos_r
        S_SL_START: begin
          sl_step_r <= 1'b1;
          nd_r      <= ROOT_NODE;
          lo_r      <= '0;
          hi_r      <= VR_C;
          state_r   <= S_SL_NODE;
        end

        S_SL_NODE: begin
          if ((lo_r + CW'(1)) >= hi_r) begin
            addr_r  <= nd_r;
            state_r <= S_SL_W;
          end else if (pos_r < mid) begin
            nd_r <= nd_left;
            hi_r <= mid;
          end else begin
            nd_r <= nd_right;
            lo_r <= mid;
          end
        end

        S_SL_W: state_r <= S_SL_RD;

        S_SL_RD: begin
          scl_r   <= tree_rdata.scale;
          mm_go_r <= 1'b1;
          mm_a_r  <= val_r;
          mm_b_r  <= tree_rdata.scale;
          state_r <= S_SL_MW;
        end

        S_SL_MW: begin
          if (mm_rsp.done) begin
            we_r          <= 1'b1;
            waddr_r       <= nd_r;
            wdata_r.sum   <= mm_rsp.res;
            wdata_r.scale <= scl_r;
            pn_r          <= nd_r >> 1;
            state_r       <= S_PL_A;
          end
        end

        // recompute sums from pn_r up to the root
        S_PL_A: begin
          addr_r  <= pn_left;
          state_r <= S_PL_AW;
        end

        S_PL_AW: state_r <= S_PL_B;

        S_PL_B: begin
          sum_a_r <= tree_rdata.sum;
          addr_r  <= pn_right;
          state_r <= S_PL_BW;
        end

        S_PL_BW: state_r <= S_PL_C;

        S_PL_C: begin
          s_r     <= addmod(sum_a_r, tree_rdata.sum);
          addr_r  <= pn_r;
          state_r <= S_PL_CW;
        end

        S_PL_CW: state_r <= S_PL_M;

        S_PL_M: begin
          scl_r   <= tree_rdata.scale;
          mm_go_r <= 1'b1;
          mm_a_r  <= tree_rdata.scale;
          mm_b_r  <= s_r;
          state_r <= S_PL_MW;
        end

        S_PL_MW: begin
          if (mm_rsp.done) begin
            we_r          <= 1'b1;
            waddr_r       <= pn_r;
            wdata_r.sum   <= mm_rsp.res;
            wdata_r.scale <= scl_r;
            if (pn_r == ROOT_NODE) begin
              root_r <= mm_rsp.res;
              if (!sl_step_r) begin
                state_r <= S_SL_START;
              end else if (op_del_r) begin
                // removal done, insert the new value
                op_del_r  <= 1'b0;
                sl_step_r <= 1'b0;
                from_r    <= CW'(tv_r) + CW'(1);
                pos_r     <= CW'(tv_r);
                z_r       <= P_BASE;
                val_r     <= tidx_r + VAL_W'(1);
                state_r   <= S_SF_START;
              end else begin
                state_r <= S_FIN;
              end
            end else begin
              pn_r    <= pn_r >> 1;
              state_r <= S_PL_A;
            end
          end
        end

        S_FIN: begin
          ring_we_r <= 1'b1;
          tidx_r    <= tidx_r + VAL_W'(1);
          if (was_full_r) target_r <= addmod(target_r, psum_r);
          else fill_r <= fill_r + PLEN_W'(1);
          state_r <= S_OUT;
        end

        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_full_r  <= full_now;
            out_match_r <= hit_now;
            out_hash_r  <= root_r;
            if (hit_now && matches_r != '1) begin
              matches_r   <= matches_r + COUNT_W'(1);
              out_count_r <= matches_r + COUNT_W'(1);
            end else begin
              out_count_r <= matches_r;
            end
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_window_full = out_full_r;
  assign out_match       = out_match_r;
  assign out_match_count = out_count_r;
  assign out_window_hash = out_hash_r;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench of order_preserving_window_matcher_unit: random and directed words,
// checked against a segment-tree predictor of the rank hash kept in this file.
// Depends on opwm_pkg and the unit under test only.
module testbench;
  import opwm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_PATTERN = 1'b0;
  localparam logic KIND_TEXT    = 1'b1;
  localparam int   TREE_RANGE   = 4096;
  localparam int   RING_MAX     = 1024;
  localparam int   TREE_NODES   = 4 * TREE_RANGE;
  localparam longint unsigned MODULUS = 64'd1000000009;
  localparam longint unsigned RADIX   = 64'd1000003;
  localparam longint unsigned RADIX_INV = 64'd27749917;

  typedef struct packed {
    logic               full;
    logic               hit;
    logic [COUNT_W-1:0] count;
    logic [VAL_W-1:0]   hash;
  } result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_req_type;
  logic [PLEN_W-1:0]  in_pattern_value;
  logic [TEXT_W-1:0]  in_text_value;
  logic               out_valid;
  logic               out_stall;
  logic               out_window_full;
  logic               out_match;
  logic [COUNT_W-1:0] out_match_count;
  logic [VAL_W-1:0]   out_window_hash;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [CFG_AW-1:0]  cfg_paddr;
  logic [CFG_DW-1:0]  cfg_pwdata;
  logic [CFG_DW-1:0]  cfg_prdata;
  logic               cfg_pready;

  order_preserving_window_matcher_unit dut (.*);

  // predictor state
  logic [VAL_W-1:0]   node_sum [TREE_NODES];
  logic [VAL_W-1:0]   node_scale [TREE_NODES];
  logic [TEXT_W-1:0]  ring [RING_MAX];
  logic [PLEN_W-1:0]  window_len_reg;
  int unsigned        fill_level;
  int unsigned        arrivals;
  logic [VAL_W-1:0]   goal_hash;
  logic [VAL_W-1:0]   radix_sum;
  logic [VAL_W-1:0]   radix_pow;
  logic [COUNT_W-1:0] hit_total;

  result_t     pending_results[$];
  int          errors;
  bit          quiet;
  int          hold_cycles;
  int unsigned words_pattern, words_text, hits_seen, results_seen;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [VAL_W-1:0] mulm(longint unsigned a, longint unsigned b);
    return VAL_W'(((a % MODULUS) * (b % MODULUS)) % MODULUS);
  endfunction

  function automatic void node_pull(int node);
    node_sum[node] = mulm(node_scale[node],
                          (64'(node_sum[2*node]) + 64'(node_sum[2*node+1])) % MODULUS);
  endfunction

  function automatic void scale_above(int node, int lo, int hi, int from,
                                      longint unsigned z);
    int mid;
    if (hi <= from || node >= TREE_NODES) return;
    if (from <= lo) begin
      node_scale[node] = mulm(node_scale[node], z);
      node_sum[node]   = mulm(node_sum[node], z);
      return;
    end
    mid = lo + ((hi - lo) >> 1);
    scale_above(2*node, lo, mid, from, z);
    scale_above(2*node+1, mid, hi, from, z);
    node_pull(node);
  endfunction

  function automatic void put_leaf(int node, int lo, int hi, int pos, longint unsigned v);
    int mid;
    if (node >= TREE_NODES) return;
    if (lo + 1 >= hi) begin
      node_sum[node] = mulm(v, node_scale[node]);
      return;
    end
    mid = lo + ((hi - lo) >> 1);
    if (pos < mid) put_leaf(2*node, lo, mid, pos, v);
    else put_leaf(2*node+1, mid, hi, pos, v);
    node_pull(node);
  endfunction

  function automatic result_t window_predict(logic kind, logic [PLEN_W-1:0] pv,
                                             logic [TEXT_W-1:0] tv);
    result_t r;
    int unsigned n;
    int unsigned slot;
    int unsigned next_idx;
    n = window_len_reg;
    if (n < 1) n = 1;
    if (n > RING_MAX) n = RING_MAX;
    r.hit = 1'b0;
    if (kind == KIND_PATTERN) begin
      goal_hash = VAL_W'((64'(goal_hash) + 64'(mulm(radix_pow, pv))) % MODULUS);
      radix_sum = VAL_W'((64'(radix_sum) + 64'(radix_pow)) % MODULUS);
      radix_pow = mulm(radix_pow, RADIX);
    end else begin
      slot = arrivals % n;
      next_idx = (arrivals + 1) & 32'h3FFF_FFFF;
      if (fill_level >= n) begin
        scale_above(1, 0, TREE_RANGE, int'(ring[slot]) + 1, RADIX_INV);
        put_leaf(1, 0, TREE_RANGE, int'(ring[slot]), 0);
        goal_hash = VAL_W'((64'(goal_hash) + 64'(radix_sum)) % MODULUS);
      end else begin
        fill_level++;
      end
      scale_above(1, 0, TREE_RANGE, int'(tv) + 1, RADIX);
      put_leaf(1, 0, TREE_RANGE, int'(tv), next_idx);
      ring[slot] = tv;
      arrivals = next_idx;
      if (fill_level >= n && node_sum[1] == goal_hash) begin
        r.hit = 1'b1;
        if (hit_total != '1) hit_total++;
      end
    end
    r.full  = (fill_level >= n);
    r.count = hit_total;
    r.hash  = node_sum[1];
    return r;
  endfunction

  // one word on the input channel; returns after the accepting edge
  task automatic send_word(logic kind, logic [PLEN_W-1:0] pv, logic [TEXT_W-1:0] tv);
    while (!quiet && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= kind;
    in_pattern_value <= pv;
    in_text_value    <= tv;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    pending_results.push_back(window_predict(kind, pv, tv));
    if (kind == KIND_PATTERN) words_pattern++;
    else words_text++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_window_len(logic [CFG_DW-1:0] value);
    drain();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= CFG_AW'(REG_PATTERN_LENGTH) << 2;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(negedge clk); while (!cfg_pready);
    @(posedge clk);
    window_len_reg = value[PLEN_W-1:0];
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random(int count, int text_pct);
    repeat (count) begin
      if ($urandom_range(0, 99) < text_pct)
        send_word(KIND_TEXT, PLEN_W'($urandom), TEXT_W'($urandom));
      else if ($urandom_range(0, 9) == 0)
        send_word(KIND_PATTERN, PLEN_W'($urandom), TEXT_W'($urandom));
      else
        send_word(KIND_PATTERN, PLEN_W'($urandom_range(1, 1024)), TEXT_W'($urandom));
    end
  endtask

  // result checker
  always begin
    result_t got;
    result_t want;
    bit take;
    @(negedge clk);
    take = out_valid && !out_stall;
    got  = '{out_window_full, out_match, out_match_count, out_window_hash};
    @(posedge clk);
    if (take) begin
      results_seen++;
      if (got.hit) hits_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word %p", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.full !== want.full) begin
          $display("%0t: window_full expected %0d actual %0d", $time, want.full, got.full);
          errors++;
        end
        if (got.hit !== want.hit) begin
          $display("%0t: match expected %0d actual %0d", $time, want.hit, got.hit);
          errors++;
        end
        if (got.count !== want.count) begin
          $display("%0t: match_count expected %0d actual %0d", $time, want.count, got.count);
          errors++;
        end
        if (got.hash !== want.hash) begin
          $display("%0t: window_hash expected %0d actual %0d", $time, want.hash, got.hash);
          errors++;
        end
      end
    end
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 22);
    end
  end

  task automatic test_pattern_at_reset();
    send_word(KIND_PATTERN, 11'd1, 12'd0);
    send_word(KIND_PATTERN, 11'd1024, 12'hFFF);
    send_word(KIND_PATTERN, 11'd2047, 12'd0);
    send_word(KIND_PATTERN, 11'd0, 12'hFFF);
    send_word(KIND_PATTERN, 11'd5, 12'd7);
  endtask

  // fill a long window from empty so that the low ring slots all get written
  task automatic test_long_window();
    set_window_len(32'h0000_07FF);
    send_word(KIND_TEXT, 11'd0, 12'd0);
    send_word(KIND_TEXT, 11'h7FF, 12'hFFF);
    send_word(KIND_TEXT, 11'd0, 12'd1);
    send_word(KIND_TEXT, 11'd0, 12'hFFE);
    send_word(KIND_TEXT, 11'd0, 12'hFFF);
    send_word(KIND_TEXT, 11'd0, 12'd0);
    send_word(KIND_TEXT, 11'd0, 12'h800);
    send_word(KIND_TEXT, 11'd0, 12'h7FF);
    set_window_len(32'd1024);
    repeat (30) send_word(KIND_TEXT, PLEN_W'($urandom), TEXT_W'($urandom));
    send_word(KIND_PATTERN, 11'd3, 12'd0);
  endtask

  task automatic test_quiet_stretch();
    quiet = 1'b1;
    send_random(120, 50);
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    drain();
    hold_cycles = 3000;
    send_random(30, 50);
  endtask

  task automatic test_sender_pause();
    drain();
    send_random(60, 50);
  endtask

  // small window: ranks are easy to line up, so feed increasing runs after the pattern
  task automatic test_short_windows();
    int base;
    set_window_len(32'd3);
    repeat (40) begin
      send_word(KIND_PATTERN, PLEN_W'($urandom_range(1, 3)), 12'd0);
      base = $urandom_range(0, 4000);
      send_word(KIND_TEXT, 11'd0, TEXT_W'(base));
      send_word(KIND_TEXT, 11'd0, TEXT_W'(base + $urandom_range(1, 40)));
      send_word(KIND_TEXT, 11'd0, TEXT_W'($urandom));
    end
    set_window_len(32'd1);
    send_random(160, 60);
    set_window_len(32'd0);
    send_random(100, 60);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = KIND_PATTERN;
    in_pattern_value = '0;
    in_text_value = '0;
    out_stall = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    errors = 0;
    quiet = 1'b0;
    hold_cycles = 0;
    words_pattern = 0;
    words_text = 0;
    hits_seen = 0;
    results_seen = 0;
    for (int i = 0; i < TREE_NODES; i++) begin
      node_sum[i] = '0;
      node_scale[i] = VAL_W'(1);
    end
    for (int i = 0; i < RING_MAX; i++) ring[i] = '0;
    window_len_reg = PLEN_W'(1);
    fill_level = 0;
    arrivals = 0;
    goal_hash = '0;
    radix_sum = '0;
    radix_pow = VAL_W'(1);
    hit_total = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pattern_at_reset();
    test_long_window();
    set_window_len(32'd32);
    send_random(320, 50);
    set_window_len(32'd8);
    test_quiet_stretch();
    test_backpressure();
    test_sender_pause();
    send_random(100, 50);
    test_short_windows();

    drain();
    repeat (200) @(posedge clk);
    $display("Covered %0d pattern and %0d text words, %0d results, %0d matching windows,",
             words_pattern, words_text, results_seen, hits_seen);
    $display("window lengths 1 to 1024 plus 0 and 2047, with stalls on both channels.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
